/* hw/rtl/rclpf_pkg.sv */
// Package for the radio control link packet framer: types, constants and frame layout.
`timescale 1ns / 1ps

package rclpf_pkg;

  localparam int unsigned FrameLen   = 16;
  localparam int unsigned IndexWidth = 4;

  localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(FrameLen - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TRANSMITTER_ID     = 2'd0,
    REG_SESSION_ID         = 2'd1,
    REG_RF_CHANNEL         = 2'd2,
    REG_VIDEO_TX_FREQUENCY = 2'd3
  } reg_index_t;

  // Reset values of the configuration registers
  localparam logic [31:0] TransmitterIdReset = 32'hDB04_2679;
  localparam logic [31:0] SessionIdReset     = 32'h0000_0000;
  localparam logic [7:0]  RfChannelReset     = 8'h00;
  localparam logic [15:0] VideoFreqReset     = 16'd5885;

  // Frame header and fixed bytes
  localparam logic [7:0] HdrFreqUpdate = 8'h40;
  localparam logic [7:0] HdrControl    = 8'h20;
  localparam logic [7:0] FreqTrailer   = 8'h82;
  localparam logic [7:0] DataByte10    = 8'h64;
  localparam logic [7:0] BindByte6     = 8'h08;
  localparam logic [7:0] BindByte7     = 8'hE4;
  localparam logic [7:0] BindByte8     = 8'hEA;
  localparam logic [7:0] BindByte9     = 8'h9E;
  localparam logic [7:0] BindByte10    = 8'h50;

  // Flag byte
  localparam logic [7:0] FlagsDefault = 8'h0E;
  localparam logic [7:0] FlagsBase    = 8'h02;
  localparam logic [7:0] FlagVideo    = 8'h01;
  localparam logic [7:0] FlagLed      = 8'h04;
  localparam logic [7:0] FlagFlip     = 8'h08;

  // Packet counter
  localparam logic [6:0] CountLimit = 7'd100;
  localparam logic [6:0] CountMax   = 7'd127;

  typedef logic [FrameLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic [31:0] transmitter_id;
    logic [31:0] session_id;
    logic [7:0]  rf_channel;
    logic [15:0] video_tx_frequency;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] bind_stage;
    logic [7:0] throttle;
    logic [7:0] rudder;
    logic [7:0] elevator;
    logic [7:0] aileron;
    logic       led_enable;
    logic       flip_enable;
    logic       video_enable;
  } req_t;

  // Status of the byte serialiser towards the input side
  typedef struct packed {
    logic busy;       // a frame is held and not yet fully sent
    logic finishing;  // the last byte is transferred at this edge
  } ser_stat_t;

endpackage

/* hw/rtl/rclpf_builder.sv */
// Frame builder: composes one 16-byte frame with checksum and keeps the link state.
`timescale 1ns / 1ps

module rclpf_builder (
  input  logic           clk,
  input  logic           rst,
  input  rclpf_pkg::cfg_t cfg,
  input  rclpf_pkg::req_t req,
  input  logic           load,
  output rclpf_pkg::frame_t frame
);
  import rclpf_pkg::*;

  logic [15:0] last_freq;
  logic [15:0] last_freq_next;
  logic [6:0]  count;
  logic [6:0]  count_next;
  logic [6:0]  count_mid;
  logic        freq_update;
  frame_t      body;
  logic [7:0]  sum_l1 [8];
  logic [7:0]  sum_l2 [4];
  logic [7:0]  sum_l3 [2];
  logic [7:0]  sum_all;

  function automatic logic [6:0] sat_inc(input logic [6:0] c);
    sat_inc = (c < CountMax) ? 7'(c + 7'd1) : c;
  endfunction

  always_comb begin
    body           = '0;
    last_freq_next = last_freq;
    count_next     = count;
    freq_update    = 1'b0;
    count_mid      = count;
    if (req.req_type) begin
      body[0]  = req.bind_stage;
      body[1]  = cfg.rf_channel;
      body[2]  = cfg.session_id[31:24];
      body[3]  = cfg.session_id[23:16];
      body[4]  = cfg.session_id[15:8];
      body[5]  = cfg.session_id[7:0];
      body[6]  = BindByte6;
      body[7]  = BindByte7;
      body[8]  = BindByte8;
      body[9]  = BindByte9;
      body[10] = BindByte10;
    end else begin
      freq_update = (cfg.video_tx_frequency != last_freq) || (count == CountLimit);
      if (freq_update) begin
        last_freq_next = cfg.video_tx_frequency;
        count_mid      = sat_inc(count);
        body[0]        = HdrFreqUpdate;
        body[1]        = cfg.video_tx_frequency[15:8];
        body[2]        = cfg.video_tx_frequency[7:0];
        body[3]        = FreqTrailer;
      end else begin
        body[0] = HdrControl;
        body[2] = req.throttle;
      end
      body[4] = ~req.rudder;
      body[6] = ~req.elevator;
      body[8] = req.aileron;
      if (count_mid < CountLimit) begin
        body[9]    = FlagsDefault;
        count_next = sat_inc(count_mid);
      end else begin
        body[9]    = FlagsBase
                   | (req.led_enable   ? FlagLed   : 8'h00)
                   | (req.flip_enable  ? FlagFlip  : 8'h00)
                   | (req.video_enable ? FlagVideo : 8'h00);
        count_next = count_mid;
      end
      body[10] = DataByte10;
    end
    body[11] = cfg.transmitter_id[31:24];
    body[12] = cfg.transmitter_id[23:16];
    body[13] = cfg.transmitter_id[15:8];
    body[14] = cfg.transmitter_id[7:0];
  end

  // Checksum: adder tree over bytes 0 to 14 (byte 15 of body is zero here).
  always_comb begin
    for (int i = 0; i < 8; i++) sum_l1[i] = 8'(body[2*i] + body[2*i+1]);
    for (int i = 0; i < 4; i++) sum_l2[i] = 8'(sum_l1[2*i] + sum_l1[2*i+1]);
    for (int i = 0; i < 2; i++) sum_l3[i] = 8'(sum_l2[2*i] + sum_l2[2*i+1]);
    sum_all = 8'(sum_l3[0] + sum_l3[1]);
  end

  always_comb begin
    frame             = body;
    frame[LastIndex]  = 8'(8'h00 - sum_all);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_freq <= '0;
      count     <= '0;
    end else if (load) begin
      last_freq <= last_freq_next;
      count     <= count_next;
    end
  end

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> count >= $past(count))
    else $error("packet count went backwards");

  a_bind_keeps_state: assert property (@(posedge clk) disable iff (rst)
    load && req.req_type |=> $stable(count) && $stable(last_freq))
    else $error("bind frame changed link state");

  a_update_records_freq: assert property (@(posedge clk) disable iff (rst)
    load && !req.req_type && freq_update |=> last_freq == $past(cfg.video_tx_frequency))
    else $error("frequency update not recorded");

endmodule

/* hw/rtl/rclpf_serializer.sv */
// Byte serialiser: holds one finished frame and sends it out one byte per transfer.
`timescale 1ns / 1ps

module rclpf_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  rclpf_pkg::frame_t             frame_in,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [7:0]                    frame_byte,
  output logic [rclpf_pkg::IndexWidth-1:0] byte_index,
  output logic                          frame_last,
  output rclpf_pkg::ser_stat_t          stat
);
  import rclpf_pkg::*;

  frame_t                frame;
  logic                  busy;
  logic [IndexWidth-1:0] idx;
  logic                  xfer;

  assign xfer           = busy && !out_stall;
  assign out_valid      = busy;
  assign byte_index     = idx;
  assign frame_byte     = frame[idx];
  assign frame_last     = (idx == LastIndex);
  assign stat.busy      = busy;
  assign stat.finishing = xfer && (idx == LastIndex);

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      idx <= IndexWidth'(idx + 1'b1);
      if (idx == LastIndex) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/rc_link_packet_framer.sv */
// Top level of the radio control link packet framer.
`timescale 1ns / 1ps

// Each accepted request builds one 16-byte radio frame, either a bind frame or
// a data frame, and sends it as sixteen byte transfers, byte 0 first, with
// frame_last high on byte 15, the checksum that makes all sixteen bytes sum
// to zero modulo 256. A request is held in an input register; the frame,
// checksum included, is composed in one pass from that register and written
// into the serialiser's frame register at the moment the previous frame's
// last byte is transferred, so that a new request is taken while a frame is
// still going out. One request is taken per frame, as the byte channel and
// out_stall allow, passing the input and serialiser frame registers before
// its first byte. The frequency-update and packet-count state advance when
// a data frame is composed, and configuration is read at that same moment, so
// registers should only be written while no request is waiting or in flight.

module rc_link_packet_framer (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  bind_stage,
  input  logic [7:0]  throttle,
  input  logic [7:0]  rudder,
  input  logic [7:0]  elevator,
  input  logic [7:0]  aileron,
  input  logic        led_enable,
  input  logic        flip_enable,
  input  logic        video_enable,
  // byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic [3:0]  byte_index,
  output logic        frame_last
);
  import rclpf_pkg::*;

  cfg_t      cfg;
  req_t      req;
  logic      req_held;
  logic      in_xfer;
  logic      load;
  frame_t    frame;
  ser_stat_t ser_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transmitter_id     <= TransmitterIdReset;
      cfg.session_id         <= SessionIdReset;
      cfg.rf_channel         <= RfChannelReset;
      cfg.video_tx_frequency <= VideoFreqReset;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TRANSMITTER_ID:     cfg.transmitter_id     <= cfg_data;
        REG_SESSION_ID:         cfg.session_id         <= cfg_data;
        REG_RF_CHANNEL:         cfg.rf_channel         <= cfg_data[7:0];
        REG_VIDEO_TX_FREQUENCY: cfg.video_tx_frequency <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The held request moves on when the serialiser is empty or is sending its
  // last byte in this cycle.
  assign load     = req_held && (!ser_stat.busy || ser_stat.finishing);
  assign in_stall = req_held && !load;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_held <= 1'b0;
    end else if (in_xfer) begin
      req_held <= 1'b1;
    end else if (load) begin
      req_held <= 1'b0;
    end
  end

  // Request payload register; it needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req.req_type     <= req_type;
      req.bind_stage   <= bind_stage;
      req.throttle     <= throttle;
      req.rudder       <= rudder;
      req.elevator     <= elevator;
      req.aileron      <= aileron;
      req.led_enable   <= led_enable;
      req.flip_enable  <= flip_enable;
      req.video_enable <= video_enable;
    end
  end

  rclpf_builder u_builder (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .req   (req),
    .load  (load),
    .frame (frame)
  );

  rclpf_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .frame_in   (frame),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .frame_last (frame_last),
    .stat       (ser_stat)
  );

  a_req_captured: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> req_held)
    else $error("accepted request not held");

  a_bytes_in_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !frame_last |=>
      out_valid && byte_index == 4'($past(byte_index) + 4'd1))
    else $error("frame bytes out of order");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && frame_last && !req_held |=> !out_valid)
    else $error("byte sent after the end of the frame");

  a_new_frame_start: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && byte_index == '0)
    else $error("new frame does not start at byte zero");

endmodule
